>>> src/prp_pkg.sv
// ----------------------------------------------------------------------------
// prp_pkg: shared types and constants for the point rotator
// Word layout between CORDIC cells, fixed widths, angle folding constants,
// arctangent table and the elaboration-time gain calculation.
// ----------------------------------------------------------------------------
package prp_pkg;

   localparam int COORD_W   = 20;   // Q16.4 coordinate
   localparam int DIFF_W    = 21;   // offset from pivot
   localparam int ANGLE_W   = 17;   // hundredths of a degree
   localparam int FOLD_W    = 18;   // folded angle arithmetic
   localparam int CORDIC_W  = 32;   // Q30 cos/sin and angle accumulator
   localparam int PROD_W    = DIFF_W + CORDIC_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int FRAC_Q    = 30;
   localparam int SHIFTED_W = SUM_W - FRAC_Q;
   localparam int RES_W     = SHIFTED_W + 1;
   localparam int ANGLE_SHIFT = 16;  // CORDIC units are 1/65536 hundredth degree
   localparam int TABLE_LEN = 24;

   localparam int CSR_W     = 20;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_PIVOT_X    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PIVOT_Y    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_ANGLE = 2'd2;

   localparam logic signed [FOLD_W-1:0] FULL_TURN     = 18'sd36000;
   localparam logic signed [FOLD_W-1:0] TWO_TURNS     = 18'sd72000;
   localparam logic signed [FOLD_W-1:0] HALF_TURN     = 18'sd18000;
   localparam logic signed [FOLD_W-1:0] QUARTER_TURN  = 18'sd9000;
   localparam logic signed [FOLD_W-1:0] THREE_QUARTER = 18'sd27000;

   localparam logic signed [SUM_W-1:0] ROUND_HALF = 54'sd536870912;
   localparam logic signed [RES_W-1:0] COORD_MAX  = 25'sd524287;
   localparam logic signed [RES_W-1:0] COORD_MIN  = -25'sd524288;

   // atan(2^-i) in 1/65536 hundredth degree
   localparam logic signed [CORDIC_W-1:0] ATAN_UNITS [TABLE_LEN] = '{
      32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
      32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
      32'sd1466765,   32'sd733385,    32'sd366693,   32'sd183346,
      32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
      32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
      32'sd358,       32'sd179,       32'sd90,       32'sd45
   };

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
      logic signed [DIFF_W-1:0]   dx;
      logic signed [DIFF_W-1:0]   dy;
   } prp_word_type;

   function automatic logic [63:0] isqrt64(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] rem;
      logic [63:0] bit_w;
      res   = 64'd0;
      rem   = v;
      bit_w = 64'd1 << 62;
      while (bit_w > rem)
         bit_w = bit_w >> 2;
      while (bit_w != 64'd0) begin
         if (rem >= res + bit_w) begin
            rem = rem - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // Q30 reciprocal of the CORDIC gain, rounded; long division by shift/subtract
   function automatic logic [63:0] gain_q30(int stages);
      logic [63:0] p;
      logic [63:0] g;
      logic [63:0] num;
      logic [63:0] rem;
      logic [63:0] quo;
      p = 64'd1 << 60;
      for (int i = 0; i < stages; i++)
         p = p + (p >> (2 * i));
      g   = isqrt64(p);
      num = (64'd1 << 60) + (g >> 1);
      rem = 64'd0;
      quo = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= g) begin
            rem    = rem - g;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

endpackage

>>> src/point_rotate_about_pivot.sv
// Pipeline from accepted word to result word: one entry stage, one cell per
// CORDIC iteration, three combine stages.
// Throughput: one word per cycle; each stage holds its word only while the
// stage after it is full and stalled, so bubbles close up under back-pressure.
// Reset: synchronous; clears all valid flags and the pivot and angle
// registers to zero.
// ----------------------------------------------------------------------------
// point_rotate_about_pivot: rotate a point about a pivot by a set angle
// Pipelined CORDIC chain produces cos/sin per word; offsets from the pivot
// are rotated, rounded, moved back by the pivot and saturated.
// ----------------------------------------------------------------------------
module point_rotate_about_pivot #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [prp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [prp_pkg::CSR_W-1:0]             csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [prp_pkg::COORD_W-1:0]    req_point_x,
   input  logic signed [prp_pkg::COORD_W-1:0]    req_point_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [prp_pkg::COORD_W-1:0]    rsp_rotated_x,
   output logic signed [prp_pkg::COORD_W-1:0]    rsp_rotated_y,
   output logic                                  rsp_clipped
);
   import prp_pkg::*;

   localparam int STAGE_N = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
   localparam logic signed [CORDIC_W-1:0] GAIN = CORDIC_W'(gain_q30(STAGE_N));

   logic signed [COORD_W-1:0]  pivot_x_ff, pivot_y_ff;
   logic signed [ANGLE_W-1:0]  turn_angle_ff;

   logic                       chain_valid [STAGE_N+1];
   logic                       chain_ready [STAGE_N+1];
   prp_word_type               chain_word  [STAGE_N+1];
   logic                       entry_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_x_ff    <= '0;
         pivot_y_ff    <= '0;
         turn_angle_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_PIVOT_X:    pivot_x_ff    <= csr_data[COORD_W-1:0];
            REG_PIVOT_Y:    pivot_y_ff    <= csr_data[COORD_W-1:0];
            REG_TURN_ANGLE: turn_angle_ff <= csr_data[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   prp_entry #(
      .GAIN_Q30 (GAIN)
   ) u_entry (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (entry_ready),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .pivot_x    (pivot_x_ff),
      .pivot_y    (pivot_y_ff),
      .turn_angle (turn_angle_ff),
      .out_valid  (chain_valid[0]),
      .out_ready  (chain_ready[0]),
      .out_word   (chain_word[0])
   );

   assign req_stall = !entry_ready;

   for (genvar i = 0; i < STAGE_N; i++) begin : g_cell
      prp_cell #(
         .SHIFT (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_word   (chain_word[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_word  (chain_word[i+1])
      );
   end

   prp_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[STAGE_N]),
      .in_ready  (chain_ready[STAGE_N]),
      .in_word   (chain_word[STAGE_N]),
      .pivot_x   (pivot_x_ff),
      .pivot_y   (pivot_y_ff),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .rotated_x (rsp_rotated_x),
      .rotated_y (rsp_rotated_y),
      .clipped   (rsp_clipped)
   );

endmodule

>>> src/prp_entry.sv
// ----------------------------------------------------------------------------
// prp_entry: angle fold and pivot offset
// Folds the turn angle into [-90, 90] degrees, loads the CORDIC start vector
// and forms the pivot offsets, negated when the half-turn flip applies.
// ----------------------------------------------------------------------------
module prp_entry #(
   parameter logic signed [31:0] GAIN_Q30 = 32'(prp_pkg::gain_q30(16))
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [prp_pkg::COORD_W-1:0]    point_x,
   input  logic signed [prp_pkg::COORD_W-1:0]    point_y,
   input  logic signed [prp_pkg::COORD_W-1:0]    pivot_x,
   input  logic signed [prp_pkg::COORD_W-1:0]    pivot_y,
   input  logic signed [prp_pkg::ANGLE_W-1:0]    turn_angle,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output prp_pkg::prp_word_type                 out_word
);
   import prp_pkg::*;

   logic                       valid_ff, valid_in;
   prp_word_type               word_ff, word_in;
   logic signed [FOLD_W-1:0]   ang, r, a;
   logic                       flip;
   logic signed [DIFF_W-1:0]   diff_x, diff_y;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      ang = FOLD_W'(turn_angle);
      if (ang < -FULL_TURN)
         r = ang + TWO_TURNS;
      else if (ang < 18'sd0)
         r = ang + FULL_TURN;
      else if (ang >= FULL_TURN)
         r = ang - FULL_TURN;
      else
         r = ang;

      flip = 1'b0;
      if (r > THREE_QUARTER) begin
         a = r - FULL_TURN;
      end else if (r > QUARTER_TURN) begin
         a    = r - HALF_TURN;
         flip = 1'b1;
      end else begin
         a = r;
      end

      diff_x = DIFF_W'(point_x) - DIFF_W'(pivot_x);
      diff_y = DIFF_W'(point_y) - DIFF_W'(pivot_y);

      // negating the offset is the same as negating cos and sin
      word_in.x  = GAIN_Q30;
      word_in.y  = '0;
      word_in.z  = CORDIC_W'(a) <<< ANGLE_SHIFT;
      word_in.dx = flip ? (DIFF_W'(0) - diff_x) : diff_x;
      word_in.dy = flip ? (DIFF_W'(0) - diff_y) : diff_y;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
      if (in_ready && in_valid)
         word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> src/prp_cell.sv
// ----------------------------------------------------------------------------
// prp_cell: one CORDIC rotation cell
// Rotates the vector by +/- atan(2^-SHIFT) toward a zero residual angle and
// carries the pivot offsets along to the next cell.
// ----------------------------------------------------------------------------
module prp_cell #(
   parameter int SHIFT = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  prp_pkg::prp_word_type  in_word,
   output logic                   out_valid,
   input  logic                   out_ready,
   output prp_pkg::prp_word_type  out_word
);
   import prp_pkg::*;

   logic                         valid_ff, valid_in;
   prp_word_type                 word_ff, word_in;
   logic signed [CORDIC_W-1:0]   x_sh, y_sh;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign x_sh = $signed(in_word.x) >>> SHIFT;
   assign y_sh = $signed(in_word.y) >>> SHIFT;

   always_comb begin
      word_in = in_word;
      if (!in_word.z[CORDIC_W-1]) begin
         word_in.x = in_word.x - y_sh;
         word_in.y = in_word.y + x_sh;
         word_in.z = in_word.z - ATAN_UNITS[SHIFT];
      end else begin
         word_in.x = in_word.x + y_sh;
         word_in.y = in_word.y - x_sh;
         word_in.z = in_word.z + ATAN_UNITS[SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
      if (in_ready && in_valid)
         word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

>>> src/prp_combine.sv
// ----------------------------------------------------------------------------
// prp_combine: apply cos/sin to the offset, round, add pivot, saturate
// Three stages: four products, rounded sums, pivot add with clamp.
// ----------------------------------------------------------------------------
module prp_combine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  prp_pkg::prp_word_type                 in_word,
   input  logic signed [prp_pkg::COORD_W-1:0]    pivot_x,
   input  logic signed [prp_pkg::COORD_W-1:0]    pivot_y,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic signed [prp_pkg::COORD_W-1:0]    rotated_x,
   output logic signed [prp_pkg::COORD_W-1:0]    rotated_y,
   output logic                                  clipped
);
   import prp_pkg::*;

   logic                          ready1, ready2, ready3;
   logic                          v1_ff, v2_ff, v3_ff;
   logic signed [PROD_W-1:0]      xc_ff, ys_ff, xs_ff, yc_ff;
   logic signed [PROD_W-1:0]      xc_in, ys_in, xs_in, yc_in;
   logic signed [SUM_W-1:0]       sum_x, sum_y;
   logic signed [SHIFTED_W-1:0]   sx_ff, sy_ff;
   logic signed [RES_W-1:0]       res_x, res_y;
   logic signed [COORD_W-1:0]     rot_x_ff, rot_y_ff, rot_x_in, rot_y_in;
   logic                          clip_ff, clip_in, hit_x, hit_y;

   assign ready3   = !v3_ff || out_ready;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   // stage 1: products (x holds cos, y holds sin)
   assign xc_in = $signed(in_word.dx) * $signed(in_word.x);
   assign ys_in = $signed(in_word.dy) * $signed(in_word.y);
   assign xs_in = $signed(in_word.dx) * $signed(in_word.y);
   assign yc_in = $signed(in_word.dy) * $signed(in_word.x);

   // stage 2: round to nearest, floor shift by taking the upper bits
   assign sum_x = SUM_W'(xc_ff) - SUM_W'(ys_ff) + ROUND_HALF;
   assign sum_y = SUM_W'(xs_ff) + SUM_W'(yc_ff) + ROUND_HALF;

   // stage 3: pivot add and clamp
   always_comb begin
      res_x = RES_W'(pivot_x) + RES_W'(sx_ff);
      res_y = RES_W'(pivot_y) + RES_W'(sy_ff);
      hit_x = 1'b1;
      hit_y = 1'b1;
      if (res_x > COORD_MAX)
         rot_x_in = COORD_MAX[COORD_W-1:0];
      else if (res_x < COORD_MIN)
         rot_x_in = COORD_MIN[COORD_W-1:0];
      else begin
         rot_x_in = res_x[COORD_W-1:0];
         hit_x    = 1'b0;
      end
      if (res_y > COORD_MAX)
         rot_y_in = COORD_MAX[COORD_W-1:0];
      else if (res_y < COORD_MIN)
         rot_y_in = COORD_MIN[COORD_W-1:0];
      else begin
         rot_y_in = res_y[COORD_W-1:0];
         hit_y    = 1'b0;
      end
      clip_in = hit_x || hit_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1)
            v1_ff <= in_valid;
         if (ready2)
            v2_ff <= v1_ff;
         if (ready3)
            v3_ff <= v2_ff;
      end
      if (ready1 && in_valid) begin
         xc_ff <= xc_in;
         ys_ff <= ys_in;
         xs_ff <= xs_in;
         yc_ff <= yc_in;
      end
      if (ready2 && v1_ff) begin
         sx_ff <= sum_x[SUM_W-1:FRAC_Q];
         sy_ff <= sum_y[SUM_W-1:FRAC_Q];
      end
      if (ready3 && v2_ff) begin
         rot_x_ff <= rot_x_in;
         rot_y_ff <= rot_y_in;
         clip_ff  <= clip_in;
      end
   end

   assign out_valid = v3_ff;
   assign rotated_x = rot_x_ff;
   assign rotated_y = rot_y_ff;
   assign clipped   = clip_ff;

endmodule
